// File: src/mouse_packet_cursor_tracker_macros.svh
// Assertion macros for the mouse packet cursor tracker, included by mpct_back.
`ifndef MOUSE_PACKET_CURSOR_TRACKER_MACROS_SVH
`define MOUSE_PACKET_CURSOR_TRACKER_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define MPCT_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define MPCT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: src/mpct_pkg.sv
// Types and constants shared by the mouse packet cursor tracker modules.
package mpct_pkg;

    localparam int BYTE_BITS      = 8;
    localparam int BUTTON_BITS    = 3;
    localparam int MOVE_Y_BITS    = 9;
    localparam int SYNC_BIT       = 3;
    localparam logic [BYTE_BITS-1:0] OVERFLOW_MASK = 8'hC0;

    localparam int CFG_DATA_BITS  = 13;
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_AREA_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_AREA_HEIGHT = 2'd1;

    localparam int DEFAULT_WIDTH  = 1024;
    localparam int DEFAULT_HEIGHT = 768;

    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_PTR_BITS = 1;
    localparam int QUEUE_CNT_BITS = 2;

    typedef enum logic [1:0] {
        BP_HEADER,
        BP_HORIZ,
        BP_VERT
    } t_byte_pos;

    // One complete, accepted packet on its way from the front to the back.
    typedef struct packed {
        logic signed [BYTE_BITS-1:0]   dx;
        logic signed [BYTE_BITS-1:0]   dy;
        logic        [BUTTON_BITS-1:0] buttons;
    } t_packet;

endpackage

// File: src/mpct_front.sv
// Byte assembler: keeps packet sync, drops overflow packets, queues good ones.
module mpct_front
    import mpct_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [BYTE_BITS-1:0] i_byte,
    output logic                 o_push,
    output t_packet              o_packet
);

    t_byte_pos             r_state, n_state;
    logic [BYTE_BITS-1:0]  r_header, n_header;
    logic [BYTE_BITS-1:0]  r_horiz, n_horiz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BP_HEADER;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_header <= n_header;
        r_horiz  <= n_horiz;
    end

    always_comb begin
        n_state  = r_state;
        n_header = r_header;
        n_horiz  = r_horiz;
        o_push   = 1'b0;
        o_packet.dx      = r_horiz;
        o_packet.dy      = i_byte;
        o_packet.buttons = r_header[BUTTON_BITS-1:0];
        if (i_accept) begin
            unique case (r_state)
                BP_HEADER: begin
                    // Only a byte with the sync bit can open a packet.
                    if (i_byte[SYNC_BIT]) begin
                        n_header = i_byte;
                        n_state  = BP_HORIZ;
                    end
                end
                BP_HORIZ: begin
                    n_horiz = i_byte;
                    n_state = BP_VERT;
                end
                BP_VERT: begin
                    n_state = BP_HEADER;
                    o_push  = ((r_header & OVERFLOW_MASK) == '0);
                end
                default: begin
                    n_state = BP_HEADER;
                end
            endcase
        end
    end

endmodule

// File: src/mpct_queue.sv
// Two-entry packet queue between the byte assembler and the cursor update.
module mpct_queue
    import mpct_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_packet i_packet,
    output logic    o_full,
    input  logic    i_pop,
    output logic    o_empty,
    output t_packet o_packet
);

    t_packet                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] r_wr_ptr, r_rd_ptr;
    logic [QUEUE_CNT_BITS-1:0] r_count;
    logic                      w_push, w_pop;

    assign o_full   = (r_count == QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign o_empty  = (r_count == '0);
    assign w_push   = i_push && !o_full;
    assign w_pop    = i_pop && !o_empty;
    assign o_packet = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_packet;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: src/mpct_back.sv
// Cursor update: applies queued packets, clamps to the area, holds the result.
`include "mouse_packet_cursor_tracker_macros.svh"
module mpct_back
    import mpct_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [CFG_INDEX_BITS-1:0]     i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      i_cfg_data,
    input  logic                          i_q_empty,
    input  t_packet                       i_packet,
    output logic                          o_q_pop,
    input  logic                          i_pop,
    output logic                          o_empty,
    output logic [COORD_BITS-1:0]         o_cursor_x,
    output logic [COORD_BITS-1:0]         o_cursor_y,
    output logic signed [BYTE_BITS-1:0]   o_move_x,
    output logic signed [MOVE_Y_BITS-1:0] o_move_y,
    output logic [BUTTON_BITS-1:0]        o_button_bits
);

    // Size registers hold up to 2^COORD_BITS, or the 1024 default when that is larger.
    localparam int SIZE_BITS = (COORD_BITS + 1 > 11) ? COORD_BITS + 1 : 11;
    localparam int POS_BITS  = SIZE_BITS - 1;
    localparam int SUM_BITS  = POS_BITS + 2;
    localparam int CMP_BITS  = (SIZE_BITS > CFG_DATA_BITS) ? SIZE_BITS : CFG_DATA_BITS;
    localparam int AREA_MAX  = 1 << COORD_BITS;

    logic [SIZE_BITS-1:0]          r_size_x, r_size_y;
    logic [POS_BITS-1:0]           r_pos_x, r_pos_y;
    logic [POS_BITS-1:0]           n_pos_x, n_pos_y;
    logic                          r_out_valid;
    logic [COORD_BITS-1:0]         r_out_x, r_out_y;
    logic signed [BYTE_BITS-1:0]   r_out_mx;
    logic signed [MOVE_Y_BITS-1:0] r_out_my;
    logic [BUTTON_BITS-1:0]        r_out_btn;
    logic                          w_take;
    logic [SIZE_BITS-1:0]          w_fixed;
    logic signed [SUM_BITS-1:0]    w_sum_x, w_sum_y;
    logic signed [MOVE_Y_BITS-1:0] w_move_y;

    function automatic logic [SIZE_BITS-1:0] fix_size(
        input logic [CFG_DATA_BITS-1:0] data,
        input logic [SIZE_BITS-1:0]     dflt
    );
        logic [CMP_BITS-1:0] ext;
        ext = CMP_BITS'(data);
        if (ext == '0) begin
            return dflt;
        end else if (ext > CMP_BITS'(AREA_MAX)) begin
            return SIZE_BITS'(AREA_MAX);
        end else begin
            return SIZE_BITS'(ext);
        end
    endfunction

    function automatic logic [POS_BITS-1:0] clamp_axis(
        input logic signed [SUM_BITS-1:0] p,
        input logic [SIZE_BITS-1:0]       size
    );
        logic [SIZE_BITS-1:0] last;
        last = size - 1'b1;
        if (p < 0) begin
            return '0;
        end else if (p >= $signed({1'b0, size})) begin
            return last[POS_BITS-1:0];
        end else begin
            return p[POS_BITS-1:0];
        end
    endfunction

    assign w_take  = !i_q_empty && (!r_out_valid || i_pop);
    assign o_q_pop = w_take;
    assign w_fixed = fix_size(i_cfg_data, (i_cfg_index == CFG_AREA_WIDTH)
                                          ? SIZE_BITS'(DEFAULT_WIDTH)
                                          : SIZE_BITS'(DEFAULT_HEIGHT));

    assign w_sum_x = $signed({2'b00, r_pos_x})
                   + {{(SUM_BITS-BYTE_BITS){i_packet.dx[BYTE_BITS-1]}}, i_packet.dx};
    assign w_sum_y = $signed({2'b00, r_pos_y})
                   - {{(SUM_BITS-BYTE_BITS){i_packet.dy[BYTE_BITS-1]}}, i_packet.dy};
    assign w_move_y = -$signed({i_packet.dy[BYTE_BITS-1], i_packet.dy});

    assign n_pos_x = clamp_axis(w_sum_x, r_size_x);
    assign n_pos_y = clamp_axis(w_sum_y, r_size_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x    <= SIZE_BITS'(DEFAULT_WIDTH);
            r_size_y    <= SIZE_BITS'(DEFAULT_HEIGHT);
            r_pos_x     <= POS_BITS'(DEFAULT_WIDTH / 2);
            r_pos_y     <= POS_BITS'(DEFAULT_HEIGHT / 2);
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            // A size write recenters its axis and wins over a packet update.
            if (i_cfg_valid && i_cfg_index == CFG_AREA_WIDTH) begin
                r_size_x <= w_fixed;
                r_pos_x  <= w_fixed[SIZE_BITS-1:1];
            end else if (w_take) begin
                r_pos_x <= n_pos_x;
            end
            if (i_cfg_valid && i_cfg_index == CFG_AREA_HEIGHT) begin
                r_size_y <= w_fixed;
                r_pos_y  <= w_fixed[SIZE_BITS-1:1];
            end else if (w_take) begin
                r_pos_y <= n_pos_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_x   <= n_pos_x[COORD_BITS-1:0];
            r_out_y   <= n_pos_y[COORD_BITS-1:0];
            r_out_mx  <= i_packet.dx;
            r_out_my  <= w_move_y;
            r_out_btn <= i_packet.buttons;
        end
    end

    assign o_empty       = !r_out_valid;
    assign o_cursor_x    = r_out_x;
    assign o_cursor_y    = r_out_y;
    assign o_move_x      = r_out_mx;
    assign o_move_y      = r_out_my;
    assign o_button_bits = r_out_btn;

    `MPCT_ASSERT_ALWAYS(a_pos_x_in_area, ({1'b0, r_pos_x} < r_size_x),
        "cursor x left the configured area")
    `MPCT_ASSERT_ALWAYS(a_pos_y_in_area, ({1'b0, r_pos_y} < r_size_y),
        "cursor y left the configured area")
    `MPCT_ASSERT_NEXT(a_result_tracks_pos, w_take && !i_cfg_valid,
        r_out_valid && r_out_x == r_pos_x[COORD_BITS-1:0] && r_out_y == r_pos_y[COORD_BITS-1:0],
        "result item does not match the updated cursor")

endmodule

// File: src/mouse_packet_cursor_tracker.sv
// Top level of the mouse packet cursor tracker.
//
// The block takes raw pointing-device bytes, one item per clock while full
// is low, and turns every good three-byte packet into one result item: the
// clamped cursor position, the packet's movement (vertical negated to screen
// sense) and the three button bits. A byte without bit 3 at packet start is
// dropped to regain sync, and a packet whose header shows an overflow bit
// gives no result. The front assembles bytes and classifies packets; a
// two-entry packet queue separates it from the back, which does one add and
// clamp per axis and holds the result in an output register. A packet's
// result passes from its queue entry into the output register. The output
// register reloads in the same cycle it is popped, so one packet per cycle
// can drain. full rises only when the output is stalled and both queue
// entries are taken. Size registers are written through the configuration
// channel, which is always ready: index 0 is the area width, index 1 the area
// height; other indexes are ignored. A zero size selects the default (1024 or
// 768), a size above 2^COORD_BITS is limited to it, and every size write
// moves that axis to half the size. Write sizes only while the block is idle.
module mouse_packet_cursor_tracker
    import mpct_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic [BYTE_BITS-1:0]          i_packet_byte,
    output logic                          o_empty,
    input  logic                          i_pop,
    output logic [COORD_BITS-1:0]         o_cursor_x,
    output logic [COORD_BITS-1:0]         o_cursor_y,
    output logic signed [BYTE_BITS-1:0]   o_move_x,
    output logic signed [MOVE_Y_BITS-1:0] o_move_y,
    output logic [BUTTON_BITS-1:0]        o_button_bits,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]     i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      i_cfg_data
);

    logic    w_accept;
    logic    w_push;
    t_packet w_front_packet;
    logic    w_q_full;
    logic    w_q_empty;
    logic    w_q_pop;
    t_packet w_q_packet;

    // Size registers take a write in any cycle.
    assign o_cfg_ready = 1'b1;

    // The queue is never full when a byte is accepted, so a completed packet
    // always finds a free entry.
    assign o_full   = w_q_full;
    assign w_accept = i_push && !w_q_full;

    mpct_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_byte   (i_packet_byte),
        .o_push   (w_push),
        .o_packet (w_front_packet)
    );

    mpct_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_packet (w_front_packet),
        .o_full   (w_q_full),
        .i_pop    (w_q_pop),
        .o_empty  (w_q_empty),
        .o_packet (w_q_packet)
    );

    mpct_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_q_empty     (w_q_empty),
        .i_packet      (w_q_packet),
        .o_q_pop       (w_q_pop),
        .i_pop         (i_pop),
        .o_empty       (o_empty),
        .o_cursor_x    (o_cursor_x),
        .o_cursor_y    (o_cursor_y),
        .o_move_x      (o_move_x),
        .o_move_y      (o_move_y),
        .o_button_bits (o_button_bits)
    );

endmodule
